// ===== rtl/sha256h_pkg.sv =====
`default_nettype none

package sha256h_pkg;

   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned LAST_ROUND  = 63;

   typedef struct packed {
      logic [31:0] msg_word;
      logic [2:0]  bytes_valid;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LENHI,
      ST_LENLO,
      ST_LOAD,
      ST_RD0,
      ST_RD1,
      ST_MIX,
      ST_RND,
      ST_UPDATE,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   // keep the valid leading bytes and append the 0x80 marker right after them
   function automatic logic [31:0] pad_partial(input logic [31:0] w, input logic [1:0] n);
      logic [31:0] r;
      unique case (n)
         2'd0: r = 32'h8000_0000;
         2'd1: r = {w[31:24], 24'h80_0000};
         2'd2: r = {w[31:16], 16'h8000};
         2'd3: r = {w[31:8], 8'h80};
      endcase
      return r;
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] r;
      unique case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] r;
      unique case (i)
         6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_hash_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_ready  req_type: msg_word, bytes_valid, last
// rsp_      out        rsp_valid/rsp_ready  rsp_type: digest_word, word_index, final_word
//
// A message word is taken while idle; the 16th word of a block starts compression.
// Compressing a block loads the chaining hash from its memory, runs 64 rounds (rounds
// 0-15 use the block words directly, 16-63 first read and mix the schedule memory) and
// adds back into the hash memory. Each digest word is read from the hash memory before
// it leaves. Padding writes one word a cycle, save while a full block compresses.
// Synchronous reset returns to idle with the initial hash; a rsp stall holds the digest
// readout, and req_ready with it, until the eighth digest word is loaded.

module sha256_hash_unit
   import sha256h_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned SW = $clog2(BLOCK_WORDS);
   localparam int unsigned HW = $clog2(HASH_WORDS);

   state_type        state_ff, state_in;
   state_type        ret_ff, ret_in;
   logic [SW-1:0]    fill_ff, fill_in;
   logic [63:0]      total_ff, total_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [5:0]       round_ff, round_in;
   logic [HASH_WORDS-1:0] hvalid_ff, hvalid_in;
   logic             hvalid_rd_ff;
   logic [HW-1:0]    hidx_rd_ff;
   logic [31:0]      v_ff [HASH_WORDS];
   logic [31:0]      v_in [HASH_WORDS];
   logic [31:0]      w16_ff, w16_in;
   logic [31:0]      w15_ff, w15_in;
   logic [31:0]      w_ff, w_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             sched_we;
   logic [SW-1:0]    sched_wa;
   logic [31:0]      sched_wd;
   logic [SW-1:0]    sched_ra_a, sched_ra_b;
   logic [31:0]      sched_rd_a, sched_rd_b;
   logic             hash_we;
   logic [31:0]      hash_wd;
   logic [31:0]      hash_rd;
   logic [31:0]      hval;

   logic             push_en;
   logic [31:0]      push_word;
   state_type        push_next;
   logic [SW-1:0]    fill_inc;
   state_type        after_pad;
   logic             sched_round;
   logic [31:0]      wt, t1, t2;

   // schedule window: two mirrored banks give two reads per cycle
   sha256h_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_sched_a (
      .clock   (clock),
      .wr_en   (sched_we),
      .wr_addr (sched_wa),
      .wr_data (sched_wd),
      .rd_addr (sched_ra_a),
      .rd_data (sched_rd_a)
   );

   sha256h_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_sched_b (
      .clock   (clock),
      .wr_en   (sched_we),
      .wr_addr (sched_wa),
      .wr_data (sched_wd),
      .rd_addr (sched_ra_b),
      .rd_data (sched_rd_b)
   );

   sha256h_ram #(.WIDTH(32), .DEPTH(HASH_WORDS)) u_hash (
      .clock   (clock),
      .wr_en   (hash_we),
      .wr_addr (hidx_rd_ff),
      .wr_data (hash_wd),
      .rd_addr (cnt_ff[HW-1:0]),
      .rd_data (hash_rd)
   );

   // an entry not yet written this message reads as the initial hash
   assign hval    = hvalid_rd_ff ? hash_rd : init_hash(hidx_rd_ff);
   assign hash_wd = hval + v_ff[hidx_rd_ff];

   assign fill_inc    = fill_ff + SW'(1);
   assign after_pad   = (fill_inc == SW'(BLOCK_WORDS - 2)) ? ST_LENHI : ST_ZERO;
   assign sched_round = (round_ff[5:4] != 2'd0);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // schedule reads: W[t-16], W[t-15] first, then W[t-7], W[t-2]
   always_comb begin
      unique case (state_ff)
         ST_RD1, ST_MIX: begin
            sched_ra_a = round_ff[SW-1:0] + SW'(9);
            sched_ra_b = round_ff[SW-1:0] + SW'(14);
         end
         default: begin
            sched_ra_a = round_ff[SW-1:0];
            sched_ra_b = round_ff[SW-1:0] + SW'(1);
         end
      endcase
   end

   assign wt = sched_round ? w_ff : sched_rd_a;
   assign t1 = v_ff[7] + big_sig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + round_k(round_ff) + wt;
   assign t2 = big_sig0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      cnt_in       = cnt_ff;
      round_in     = round_ff;
      hvalid_in    = hvalid_ff;
      v_in         = v_ff;
      w16_in       = w16_ff;
      w15_in       = w15_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      sched_we     = 1'b0;
      sched_wa     = round_ff[SW-1:0];
      sched_wd     = w_ff;
      hash_we      = 1'b0;
      push_en      = 1'b0;
      push_word    = '0;
      push_next    = ST_IDLE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               push_en = 1'b1;
               if (!req_data.last) begin
                  push_word = req_data.msg_word;
                  push_next = ST_IDLE;
                  total_in  = total_ff + 64'd4;
               end else if (req_data.bytes_valid >= 3'd4) begin
                  push_word = req_data.msg_word;
                  push_next = ST_MARK;
                  total_in  = total_ff + 64'd4;
               end else begin
                  push_word = pad_partial(req_data.msg_word, req_data.bytes_valid[1:0]);
                  push_next = after_pad;
                  total_in  = total_ff + {62'd0, req_data.bytes_valid[1:0]};
               end
            end
         end
         ST_MARK: begin
            push_en   = 1'b1;
            push_word = 32'h8000_0000;
            push_next = after_pad;
         end
         ST_ZERO: begin
            push_en   = 1'b1;
            push_next = after_pad;
         end
         ST_LENHI: begin
            push_en   = 1'b1;
            push_word = total_ff[60:29];
            push_next = ST_LENLO;
         end
         ST_LENLO: begin
            push_en   = 1'b1;
            push_word = {total_ff[28:0], 3'b000};
            push_next = ST_OUT_RD;
         end
         ST_LOAD: begin
            if (cnt_ff != 4'd0) begin
               v_in[hidx_rd_ff] = hval;
            end
            if (cnt_ff == 4'(HASH_WORDS)) begin
               state_in = ST_RD0;
               cnt_in   = 4'd0;
               round_in = '0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_RD0: begin
            state_in = sched_round ? ST_RD1 : ST_RND;
         end
         ST_RD1: begin
            w16_in   = sched_rd_a;
            w15_in   = sched_rd_b;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            w_in     = w16_ff + small_sig0(w15_ff) + sched_rd_a + small_sig1(sched_rd_b);
            state_in = ST_RND;
         end
         ST_RND: begin
            // schedule word goes back into its slot; later rounds read it well after
            sched_we = sched_round;
            for (int i = HASH_WORDS - 1; i > 0; i--) begin
               v_in[i] = v_ff[i-1];
            end
            v_in[4] = v_ff[3] + t1;
            v_in[0] = t1 + t2;
            if (round_ff == 6'(LAST_ROUND)) begin
               state_in = ST_UPDATE;
               cnt_in   = 4'd0;
            end else begin
               round_in = round_ff + 6'd1;
               state_in = ST_RD0;
            end
         end
         ST_UPDATE: begin
            if (cnt_ff != 4'd0) begin
               hash_we               = 1'b1;
               hvalid_in[hidx_rd_ff] = 1'b1;
            end
            if (cnt_ff == 4'(HASH_WORDS)) begin
               state_in = ret_ff;
               cnt_in   = 4'd0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.digest_word = hval;
               rsp_data_in.word_index  = cnt_ff[HW-1:0];
               rsp_data_in.final_word  = (cnt_ff == 4'(HASH_WORDS - 1));
               if (cnt_ff == 4'(HASH_WORDS - 1)) begin
                  state_in  = ST_IDLE;
                  cnt_in    = 4'd0;
                  fill_in   = '0;
                  total_in  = '0;
                  hvalid_in = '0;
               end else begin
                  cnt_in   = cnt_ff + 4'd1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one word into the block; a full block detours through compression
      if (push_en) begin
         sched_we = 1'b1;
         sched_wa = fill_ff;
         sched_wd = push_word;
         fill_in  = fill_inc;
         if (fill_ff == SW'(BLOCK_WORDS - 1)) begin
            state_in = ST_LOAD;
            ret_in   = push_next;
            cnt_in   = 4'd0;
         end else begin
            state_in = push_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         fill_ff      <= '0;
         total_ff     <= '0;
         cnt_ff       <= '0;
         round_ff     <= '0;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         cnt_ff       <= cnt_in;
         round_ff     <= round_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hvalid_rd_ff <= hvalid_ff[cnt_ff[HW-1:0]];
      hidx_rd_ff   <= cnt_ff[HW-1:0];
      v_ff         <= v_in;
      w16_ff       <= w16_in;
      w15_ff       <= w15_in;
      w_ff         <= w_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_sched_wr_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RND && sched_we) |-> sched_round)
      else $error("schedule written in a round that reads the block directly");

   a_update_all_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && cnt_ff == 4'(HASH_WORDS)) |=> (hvalid_ff == '1))
      else $error("hash memory not fully written after update");

   a_digest_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_RD) |-> (fill_ff == '0))
      else $error("digest read with a partial block pending");

   a_full_block_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_data.last && fill_ff == SW'(BLOCK_WORDS - 1))
      |=> (state_ff == ST_LOAD && !req_ready))
      else $error("block full but intake not held");
`endif

endmodule

`default_nettype wire

// ===== rtl/sha256h_ram.sv =====
`default_nettype none

module sha256h_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sim/sha256_hash_unit_test.sv =====
`default_nettype none

module sha256_hash_unit_test
   import sha256h_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_WORDS = 320;
   localparam int unsigned LIMIT_CYCLES = 500_000;
   localparam int unsigned HOLD_CYCLES  = 800;
   localparam int unsigned HOLD_AFTER   = 64;
   localparam int unsigned LEN_SLOT     = 14;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   localparam logic [0:7][31:0] IV_WORDS = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [0:63][31:0] K_WORDS = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct {
      req_type      word;
      bit           known;
      logic [255:0] digest;
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned send_idle_pct = 16;
   int unsigned recv_idle_pct = 86;
   int unsigned error_count = 0;
   int unsigned digest_words_seen = 0;
   int unsigned cycle_count = 0;

   rsp_type     digest_expected[$];
   dir_row_type directed_rows[$];

   // running hash state
   logic [0:7][31:0] chain_h;
   logic [31:0]      blk_buf [16];
   int unsigned      blk_fill;
   logic [63:0]      msg_bytes;

   sha256_hash_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_hash();
      chain_h   = IV_WORDS;
      blk_fill  = 0;
      msg_bytes = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            w[i] = blk_buf[i];
         end else begin
            s0   = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1   = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
      end
      {a, b, c, d, e, f, g, h} = chain_h;
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + K_WORDS[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g;
         g = f;
         f = e;
         e = d + t1;
         d = c;
         c = b;
         b = a;
         a = t1 + t2;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
      chain_h[5] += f;
      chain_h[6] += g;
      chain_h[7] += h;
   endfunction

   function automatic void load_block_word(input logic [31:0] w);
      blk_buf[blk_fill] = w;
      blk_fill++;
      if (blk_fill == 16) begin
         compress_block();
         blk_fill = 0;
      end
   endfunction

   // fold one word into the hash; on the last word pad, finish and return 1
   function automatic bit absorb_word(input req_type w, output logic [255:0] digest);
      int unsigned nb;
      logic [31:0] keep;
      logic [63:0] bit_len;
      digest = '0;
      if (!w.last) begin
         msg_bytes += 64'd4;
         load_block_word(w.msg_word);
         return 1'b0;
      end
      nb = (w.bytes_valid > 3'd4) ? 4 : w.bytes_valid;
      msg_bytes += 64'(nb);
      if (nb == 4) begin
         load_block_word(w.msg_word);
         load_block_word(32'h8000_0000);
      end else begin
         keep = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
         load_block_word((w.msg_word & keep) | (32'h80 << (24 - 8 * nb)));
      end
      while (blk_fill != LEN_SLOT) load_block_word(32'h0);
      bit_len = msg_bytes << 3;
      load_block_word(bit_len[63:32]);
      load_block_word(bit_len[31:0]);
      digest = chain_h;
      restart_hash();
      return 1'b1;
   endfunction

   function automatic dir_row_type dir_row(input logic [31:0] w, input logic [2:0] n,
                                           input bit l, input bit k, input logic [255:0] d);
      dir_row_type r;
      r.word.msg_word    = w;
      r.word.bytes_valid = n;
      r.word.last        = l;
      r.known            = k;
      r.digest           = d;
      return r;
   endfunction

   // offer one word, hold it until taken, then queue its digest if it closes a message
   task automatic send_word(input req_type w, input bit known, input logic [255:0] known_digest);
      logic [255:0] digest;
      int unsigned gap;
      rsp_type exp_word;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      if (absorb_word(w, digest)) begin
         if (known) digest = known_digest;
         for (int j = 0; j < 8; j++) begin
            exp_word.digest_word = digest[255 - 32 * j -: 32];
            exp_word.word_index  = 3'(j);
            exp_word.final_word  = (j == 7);
            digest_expected.push_back(exp_word);
         end
      end
   endtask

   initial begin
      req_type w;
      int unsigned random_words;
      int unsigned body_len;
      int unsigned pick;

      random_words = 0;
      restart_hash();
      directed_rows.push_back(dir_row(32'hdead_beef, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST));
      // stray byte after "abc" must be masked off
      directed_rows.push_back(dir_row(32'h6162_63ff, 3'd3, 1'b1, 1'b1, ABC_DIGEST));
      directed_rows.push_back(dir_row(32'hffff_ffff, 3'd1, 1'b1, 1'b0, '0));
      directed_rows.push_back(dir_row(32'h0000_0000, 3'd2, 1'b1, 1'b0, '0));
      directed_rows.push_back(dir_row(32'hffff_ffff, 3'd4, 1'b1, 1'b0, '0));
      directed_rows.push_back(dir_row(32'h0000_0000, 3'd4, 1'b1, 1'b0, '0));
      // byte counts on non-final words are don't-care
      directed_rows.push_back(dir_row(32'h1234_5678, 3'd1, 1'b0, 1'b0, '0));
      directed_rows.push_back(dir_row(32'hffff_ffff, 3'd7, 1'b0, 1'b0, '0));
      directed_rows.push_back(dir_row(32'h0000_0000, 3'd0, 1'b0, 1'b0, '0));
      // counts above four clamp to a full word
      directed_rows.push_back(dir_row(32'ha5a5_a5a5, 3'd5, 1'b1, 1'b0, '0));
      directed_rows.push_back(dir_row(32'h5a5a_5a5a, 3'd6, 1'b1, 1'b0, '0));
      directed_rows.push_back(dir_row(32'hffff_ffff, 3'd7, 1'b1, 1'b0, '0));
      directed_rows.push_back(dir_row(32'h8000_0001, 3'd3, 1'b1, 1'b0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].digest);

      while (random_words < RANDOM_WORDS) begin
         if (random_words < RANDOM_WORDS / 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 86;
         end else if (random_words < 2 * RANDOM_WORDS / 3) begin
            send_idle_pct = 86;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // mostly short messages, some ending near the length slot, a few multi-block
         pick = $urandom_range(9);
         if (pick < 6)      body_len = $urandom_range(17, 0);
         else if (pick < 8) body_len = $urandom_range(15, 12);
         else               body_len = $urandom_range(47, 28);
         for (int i = 0; i <= body_len; i++) begin
            w.msg_word    = $urandom;
            w.bytes_valid = 3'($urandom_range(7, 0));
            w.last        = (i == body_len);
            send_word(w, 1'b0, '0);
            random_words++;
         end
      end
      req_valid <= 1'b0;

      while (digest_expected.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // receiver: random stalls, plus one long hold-off so the block backs up its input
   initial begin
      int unsigned hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && digest_words_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         digest_words_seen++;
         if (digest_expected.size() == 0) begin
            $error("unexpected digest word %h index %0d", rsp_data.digest_word,
                   rsp_data.word_index);
            error_count++;
         end else begin
            want = digest_expected.pop_front();
            if (rsp_data.digest_word !== want.digest_word) begin
               $error("digest_word: expected %h, got %h", want.digest_word,
                      rsp_data.digest_word);
               error_count++;
            end
            if (rsp_data.word_index !== want.word_index) begin
               $error("word_index: expected %0d, got %0d", want.word_index,
                      rsp_data.word_index);
               error_count++;
            end
            if (rsp_data.final_word !== want.final_word) begin
               $error("final_word: expected %b, got %b", want.final_word,
                      rsp_data.final_word);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
